// ----- rtl/core/sm4_pkg.sv -----
package sm4_pkg;

	localparam int BLK_W = 128;
	localparam int WORD_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IV_HI = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IV_LO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd5;

	localparam logic [BLK_W-1:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

	typedef struct packed {
		logic load;
		logic step;
		logic key_sched;
	} sm4_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] tau(input logic [31:0] x);
		return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	// data-path linear map: b ^ rotl 2, 10, 18, 24
	function automatic logic [31:0] lin_data(input logic [31:0] b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
			^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

	// key-schedule linear map: b ^ rotl 13, 23
	function automatic logic [31:0] lin_key(input logic [31:0] b);
		return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

	// CK byte j of round i is (4i + j) * 7 mod 256
	function automatic logic [31:0] ck_word(input logic [7:0] i);
		logic [31:0] v;
		logic [7:0] n;
		v = '0;
		for (int j = 0; j < 4; j++) begin
			n = (i << 2) + 8'(j);
			v = {v[23:0], 8'((n << 3) - n)};
		end
		return v;
	endfunction

endpackage

// ----- rtl/core/sm4_block_cipher_ecb_cbc_core.sv -----
// SM4 block engine, ECB or CBC, encrypt or decrypt. A word is taken only
// while the engine is idle (in_stall low); it is then held through the
// accept cycle, the 32 rounds through the single round unit, and the finish
// cycle that moves the result into the output register, which may still
// hold an untaken word while the next one is accepted. The finish cycle
// repeats while the output register holds an untaken, stalled word. After
// any write to the key registers the next word first runs the key schedule
// on the same round unit, writing one round key per cycle into the 32-entry
// key memory. Round keys are read from the registered memory in the cycle
// before the round that uses them. The user must write registers only while
// idle; the block itself does not enforce this.
module sm4_block_cipher_ecb_cbc_core #(
	parameter int ROUND_COUNT = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sm4_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sm4_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [63:0]                     block_hi,
	input  logic [63:0]                     block_lo,
	input  logic                            first_block,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [63:0]                     out_hi,
	output logic [63:0]                     out_lo
);
	import sm4_pkg::*;

	localparam int AW = $clog2(ROUND_COUNT);
	localparam logic [AW-1:0] LAST = AW'(ROUND_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ROUND,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic [AW-1:0] cnt_q;
	logic keys_stale_q;
	logic [127:0] key_q, iv_q, chain_q;
	logic chain_mode_q, decrypt_mode_q;
	logic [127:0] blk_q, mask_q;
	logic out_valid_q;
	logic [63:0] out_hi_q, out_lo_q;

	logic in_acc, out_free, cbc_enc, cbc_dec;
	logic [127:0] block, chain_use, crypt_in, load_data, result;
	logic [AW-1:0] cnt_next, rd_step, rd_addr;
	logic [31:0] ck, rk, nx;
	sm4_ctl_t ctl;

	always_comb begin
		in_stall = state_q != ST_IDLE;
		in_acc = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		cbc_enc = chain_mode_q && !decrypt_mode_q;
		cbc_dec = chain_mode_q && decrypt_mode_q;
		block = {block_hi, block_lo};
		chain_use = first_block ? iv_q : chain_q;
		crypt_in = cbc_enc ? (block ^ chain_use) : block;
		load_data = (state_q == ST_IDLE) ? (keys_stale_q ? (key_q ^ FK) : crypt_in) : blk_q;
		cnt_next = cnt_q + 1'b1;
		// key for the round after this one; round 0 is fetched while not in rounds
		rd_step = (state_q == ST_ROUND) ? cnt_next : '0;
		rd_addr = decrypt_mode_q ? (LAST - rd_step) : rd_step;
		ck = ck_word(8'(cnt_q));
		ctl.load = (state_q == ST_IDLE && in_acc) || (state_q == ST_EXPAND && cnt_q == LAST);
		ctl.step = state_q == ST_EXPAND || state_q == ST_ROUND;
		ctl.key_sched = state_q == ST_EXPAND;
	end

	sm4_rkmem #(
		.DEPTH(ROUND_COUNT),
		.AW(AW)
	) u_rkmem (
		.clk(clk),
		.we(state_q == ST_EXPAND),
		.waddr(cnt_q),
		.wdata(nx),
		.raddr(rd_addr),
		.rdata(rk)
	);

	sm4_datapath u_datapath (
		.clk(clk),
		.ctl(ctl),
		.load_data(load_data),
		.ck(ck),
		.rk(rk),
		.nx(nx),
		.state(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q <= '0;
			chain_mode_q <= 1'b0;
			decrypt_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_HI: key_q[127:64] <= cfg_data;
				REG_KEY_LO: key_q[63:0] <= cfg_data;
				REG_IV_HI: iv_q[127:64] <= cfg_data;
				REG_IV_LO: iv_q[63:0] <= cfg_data;
				REG_CHAIN_MODE: chain_mode_q <= cfg_data[0];
				REG_DECRYPT_MODE: decrypt_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			blk_q <= crypt_in;
			mask_q <= cbc_dec ? chain_use : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			keys_stale_q <= 1'b1;
			chain_q <= '0;
			out_valid_q <= 1'b0;
			out_hi_q <= '0;
			out_lo_q <= '0;
		end else begin
			// the finish cycle handles the output register itself
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						if (cbc_dec) begin
							chain_q <= block;
						end
						if (keys_stale_q) begin
							keys_stale_q <= 1'b0;
							state_q <= ST_EXPAND;
						end else begin
							state_q <= ST_ROUND;
						end
					end
				end
				ST_EXPAND: begin
					if (cnt_q == LAST) begin
						cnt_q <= '0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_next;
					end
				end
				ST_ROUND: begin
					if (cnt_q == LAST) begin
						cnt_q <= '0;
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_next;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_hi_q <= result[127:64] ^ mask_q[127:64];
						out_lo_q <= result[63:0] ^ mask_q[63:0];
						if (cbc_enc) begin
							chain_q <= result;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we && (cfg_index == REG_KEY_HI || cfg_index == REG_KEY_LO)) begin
				keys_stale_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_hi = out_hi_q;
	assign out_lo = out_lo_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_EXPAND || state_q == ST_ROUND))
		else $error("accepted word did not start processing");

	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_FINISH) |-> cnt_q == '0)
		else $error("round counter not cleared outside processing");

	a_finish_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished word not delivered");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("output word appeared without a finished block");

endmodule

// ----- rtl/core/sm4_rkmem.sv -----
module sm4_rkmem #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// last round key is read in the same cycle it is written when decrypt follows expansion
	always_ff @(posedge clk) begin
		if (we && waddr == raddr) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/sm4_datapath.sv -----
module sm4_datapath (
	input  logic                    clk,
	input  sm4_pkg::sm4_ctl_t       ctl,
	input  logic [sm4_pkg::BLK_W-1:0] load_data,
	input  logic [31:0]             ck,
	input  logic [31:0]             rk,
	output logic [31:0]             nx,
	output logic [sm4_pkg::BLK_W-1:0] state
);
	import sm4_pkg::*;

	logic [31:0] x0_q, x1_q, x2_q, x3_q;
	logic [31:0] key_in;
	logic [31:0] mix;
	logic [31:0] sub;

	always_comb begin
		key_in = ctl.key_sched ? ck : rk;
		mix = x1_q ^ x2_q ^ x3_q ^ key_in;
		sub = tau(mix);
		nx = x0_q ^ (ctl.key_sched ? lin_key(sub) : lin_data(sub));
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x0_q <= load_data[127:96];
			x1_q <= load_data[95:64];
			x2_q <= load_data[63:32];
			x3_q <= load_data[31:0];
		end else if (ctl.step) begin
			x0_q <= x1_q;
			x1_q <= x2_q;
			x2_q <= x3_q;
			x3_q <= nx;
		end
	end

	// final reverse word order
	assign state = {x3_q, x2_q, x1_q, x0_q};

endmodule

// ----- tb/tb_sm4_block_cipher_ecb_cbc_core.sv -----
`timescale 1ns / 1ps

module tb_sm4_block_cipher_ecb_cbc_core;
	import sm4_pkg::*;

	localparam int ITEM_TOTAL = 1550;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 80;

	// indexes past the register list; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = '0;

	localparam logic [31:0] FK_W [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

	localparam logic [7:0] SUB_LUT [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [63:0] a;       // register data, or upper block half
		logic [63:0] b;       // lower block half
		logic fb;
		logic known;
		logic [127:0] res;
	} dir_row_t;

	localparam int DIR_ROWS = 32;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// zero key straight out of reset, ECB encrypt
		'{ROW_WORD, IDX_UNUSED, 64'h0, 64'h0, 1'b0, 1'b0, 128'h0},
		// ECB ignores first_block
		'{ROW_WORD, IDX_UNUSED, '1, '1, 1'b1, 1'b0, 128'h0},
		'{ROW_CFG, REG_KEY_HI, 64'h0123456789abcdef, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_CFG, REG_KEY_LO, 64'hfedcba9876543210, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b1,
			128'h681edf34d206965e86b3e94f536e4246},
		// only bit 0 of a mode register counts
		'{ROW_CFG, REG_DECRYPT_MODE, '1, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0, 1'b1,
			128'h0123456789abcdeffedcba9876543210},
		'{ROW_CFG, REG_DECRYPT_MODE, 64'hffff_ffff_ffff_fffe, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_CFG, REG_CHAIN_MODE, 64'h1, 64'h0, 1'b0, 1'b0, 128'h0},
		// CBC with no first word yet: chain is still zero
		'{ROW_WORD, IDX_UNUSED, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b1,
			128'h681edf34d206965e86b3e94f536e4246},
		'{ROW_WORD, IDX_UNUSED, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 1'b0, 1'b0, 128'h0},
		'{ROW_CFG, REG_IV_HI, '1, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_CFG, REG_IV_LO, 64'h0, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'h0, 64'h0, 1'b1, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, '1, '1, 1'b0, 1'b0, 128'h0},
		// IV change mid-message waits for the next first word
		'{ROW_CFG, REG_IV_HI, 64'h0, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'h123456789abcdef0, 64'h0fedcba987654321, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'hfedcba9876543210, 64'h0123456789abcdef, 1'b1, 1'b0, 128'h0},
		'{ROW_CFG, REG_DECRYPT_MODE, 64'h1, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'h8000000000000000, 64'h0000000000000001, 1'b1, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'h7fffffffffffffff, 64'hfffffffffffffffe, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'hdeadbeefcafef00d, 64'h0011223344556677, 1'b0, 1'b0, 128'h0},
		'{ROW_CFG, REG_SPARE_A, '1, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_CFG, REG_SPARE_B, 64'h0123456789abcdef, 64'h0, 1'b0, 1'b0, 128'h0},
		// new key in the middle of a CBC message
		'{ROW_CFG, REG_KEY_HI, '1, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_CFG, REG_KEY_LO, '1, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 1'b0, 1'b0, 128'h0},
		'{ROW_CFG, REG_CHAIN_MODE, 64'hffff_ffff_ffff_fffe, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'h8000000000000000, 64'h0000000000000001, 1'b1, 1'b0, 128'h0},
		'{ROW_CFG, REG_DECRYPT_MODE, 64'h0, 64'h0, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, 64'h0000000000000001, 64'h8000000000000000, 1'b0, 1'b0, 128'h0},
		'{ROW_WORD, IDX_UNUSED, '1, 64'h0, 1'b1, 1'b0, 128'h0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] block_hi = '0;
	logic [63:0] block_lo = '0;
	logic first_block = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] out_hi;
	logic [63:0] out_lo;

	// predictor state
	logic [127:0] cur_key = '0;
	logic [127:0] cur_iv = '0;
	logic cbc_on = 1'b0;
	logic dec_on = 1'b0;
	logic [31:0] sched [32];
	logic sched_stale = 1'b1;
	logic [127:0] chain_q = '0;

	logic [127:0] cipher_q [$];
	int err_cnt = 0;
	int words_sent = 0;
	int rx_hold = 0;
	int quiet_cnt = 0;
	logic idle_on = 1'b1;

	sm4_block_cipher_ecb_cbc_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.block_hi(block_hi),
		.block_lo(block_lo),
		.first_block(first_block),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_hi(out_hi),
		.out_lo(out_lo)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] x);
		return {SUB_LUT[x[31:24]], SUB_LUT[x[23:16]], SUB_LUT[x[15:8]], SUB_LUT[x[7:0]]};
	endfunction

	// one block through the cipher, updating the schedule and CBC chain
	function automatic logic [127:0] sm4_predict(input logic [127:0] blk, input logic fb);
		logic [31:0] k [4];
		logic [31:0] x [4];
		logic [31:0] ck, b, nxt;
		logic [127:0] src, res;
		if (sched_stale) begin
			for (int j = 0; j < 4; j++)
				k[j] = cur_key[127 - 32*j -: 32] ^ FK_W[j];
			for (int i = 0; i < 32; i++) begin
				ck = '0;
				for (int j = 0; j < 4; j++)
					ck = {ck[23:0], 8'((4*i + j) * 7)};
				b = sbox_word(k[1] ^ k[2] ^ k[3] ^ ck);
				nxt = k[0] ^ b ^ rol32(b, 13) ^ rol32(b, 23);
				sched[i] = nxt;
				k[0] = k[1];
				k[1] = k[2];
				k[2] = k[3];
				k[3] = nxt;
			end
			sched_stale = 1'b0;
		end
		if (cbc_on && fb)
			chain_q = cur_iv;
		src = (cbc_on && !dec_on) ? blk ^ chain_q : blk;
		for (int j = 0; j < 4; j++)
			x[j] = src[127 - 32*j -: 32];
		for (int i = 0; i < 32; i++) begin
			b = sbox_word(x[1] ^ x[2] ^ x[3] ^ sched[dec_on ? 31 - i : i]);
			nxt = x[0] ^ b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = nxt;
		end
		res = {x[3], x[2], x[1], x[0]};
		if (cbc_on) begin
			if (dec_on) begin
				res = res ^ chain_q;
				chain_q = blk;
			end else begin
				chain_q = res;
			end
		end
		return res;
	endfunction

	// caller lowers cfg_we after the last write of a batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_KEY_HI: begin
				cur_key[127:64] = val;
				sched_stale = 1'b1;
			end
			REG_KEY_LO: begin
				cur_key[63:0] = val;
				sched_stale = 1'b1;
			end
			REG_IV_HI: cur_iv[127:64] = val;
			REG_IV_LO: cur_iv[63:0] = val;
			REG_CHAIN_MODE: cbc_on = val[0];
			REG_DECRYPT_MODE: dec_on = val[0];
			default: ;
		endcase
	endtask

	// valid stays high on return so back-to-back words never drop it
	task automatic push_word(input logic [63:0] hi, input logic [63:0] lo, input logic fb,
			input logic known, input logic [127:0] res);
		int gap;
		logic [127:0] pred;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		block_hi <= hi;
		block_lo <= lo;
		first_block <= fb;
		do @(posedge clk); while (in_stall);
		pred = sm4_predict({hi, lo}, fb);
		cipher_q.push_back(known ? res : pred);
		words_sent++;
	endtask

	task automatic drain_words();
		in_valid <= 1'b0;
		do @(posedge clk); while (cipher_q.size() != 0);
	endtask

	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (cipher_q.size() == 0) begin
				$display("%0t: unexpected word %h_%h", $time, out_hi, out_lo);
				err_cnt++;
			end else begin
				want = cipher_q.pop_front();
				if (out_hi !== want[127:64]) begin
					$display("%0t: out_hi expected %h got %h", $time, want[127:64], out_hi);
					err_cnt++;
				end
				if (out_lo !== want[63:0]) begin
					$display("%0t: out_lo expected %h got %h", $time, want[63:0], out_lo);
					err_cnt++;
				end
			end
			rx_hold = idle_on ? $urandom_range(0, 10) : 0;
		end else if (out_valid && rx_hold != 0) begin
			rx_hold--;
		end
		out_stall <= (rx_hold != 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cnt = 0;
		else
			quiet_cnt++;
		if (quiet_cnt >= QUIET_LIMIT) begin
			$display("[sm4_block_cipher_ecb_cbc_core] ERROR");
			$finish;
		end
	end

	initial begin
		logic prev_cfg;
		logic all_regs;
		logic [63:0] val;
		int pick;
		int msg_len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_cfg = 1'b0;
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIR_TAB[r].kind == ROW_CFG) begin
				if (!prev_cfg)
					drain_words();
				write_reg(DIR_TAB[r].idx, DIR_TAB[r].a);
				prev_cfg = 1'b1;
			end else begin
				if (prev_cfg)
					cfg_we <= 1'b0;
				push_word(DIR_TAB[r].a, DIR_TAB[r].b, DIR_TAB[r].fb,
					DIR_TAB[r].known, DIR_TAB[r].res);
				prev_cfg = 1'b0;
			end
		end

		all_regs = 1'b1;
		while (words_sent < ITEM_TOTAL) begin
			drain_words();
			idle_on = ($urandom_range(0, 3) != 0);
			for (int r = 0; r < 8; r++) begin
				if (all_regs || $urandom_range(0, 2) == 0) begin
					pick = $urandom_range(0, 9);
					val = {$urandom, $urandom};
					if (r <= REG_IV_LO && pick == 0)
						val = '0;
					else if (r <= REG_IV_LO && pick == 1)
						val = '1;
					write_reg(r[CFG_IDX_W-1:0], val);
				end
			end
			all_regs = 1'b0;
			cfg_we <= 1'b0;
			// mostly proper messages: first word flagged, rest chained
			msg_len = $urandom_range(1, 24);
			for (int i = 0; i < msg_len; i++)
				push_word({$urandom, $urandom}, {$urandom, $urandom},
					(i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0),
					1'b0, '0);
		end

		drain_words();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("[sm4_block_cipher_ecb_cbc_core] OK");
		else
			$display("[sm4_block_cipher_ecb_cbc_core] ERROR");
		$finish;
	end

endmodule
